@@ sv/cso_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the cadence/speed odometer.
// Used by cso_div and cadence_speed_odometer; depends on nothing else.

package cso_pkg;

    localparam int DIVIDEND_W = 18;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVIDEND_W);

    localparam int RPM_W      = 11;
    localparam int SPEED_W    = 12;
    localparam int DIST_W     = 32;
    localparam int CIRC_W     = 12;
    localparam int MAG_W      = 7;
    localparam int COUNT_W    = 13;
    localparam int ODO_INC_W  = 9;

    localparam logic [MAG_W-1:0] MAG_MAX = 7'd64;

    // reciprocal of ten in 16 fractional bits, exact for 12-bit circumferences
    localparam logic [12:0] RECIP_TEN = 13'd6554;
    localparam logic [COUNT_W-1:0] REVS_PER_STEP = 13'd100;

    // configuration register indexes
    localparam logic [3:0] CFG_PEDAL_MIN  = 4'd0;
    localparam logic [3:0] CFG_WHEEL_MIN  = 4'd1;
    localparam logic [3:0] CFG_PEDAL_TO   = 4'd2;
    localparam logic [3:0] CFG_WHEEL_TO   = 4'd3;
    localparam logic [3:0] CFG_CIRC       = 4'd4;
    localparam logic [3:0] CFG_START_DIST = 4'd5;
    localparam logic [3:0] CFG_PEDAL_MAG  = 4'd6;
    localparam logic [3:0] CFG_WHEEL_MAG  = 4'd7;

    // 60000 / magnets, indexed by magnets - 1
    localparam logic [15:0] PEDAL_NUM [64] = '{
        16'd60000, 16'd30000, 16'd20000, 16'd15000, 16'd12000, 16'd10000, 16'd8571, 16'd7500,
        16'd6666,  16'd6000,  16'd5454,  16'd5000,  16'd4615,  16'd4285,  16'd4000, 16'd3750,
        16'd3529,  16'd3333,  16'd3157,  16'd3000,  16'd2857,  16'd2727,  16'd2608, 16'd2500,
        16'd2400,  16'd2307,  16'd2222,  16'd2142,  16'd2068,  16'd2000,  16'd1935, 16'd1875,
        16'd1818,  16'd1764,  16'd1714,  16'd1666,  16'd1621,  16'd1578,  16'd1538, 16'd1500,
        16'd1463,  16'd1428,  16'd1395,  16'd1363,  16'd1333,  16'd1304,  16'd1276, 16'd1250,
        16'd1224,  16'd1200,  16'd1176,  16'd1153,  16'd1132,  16'd1111,  16'd1090, 16'd1071,
        16'd1052,  16'd1034,  16'd1016,  16'd1000,  16'd983,   16'd967,   16'd952,  16'd937
    };

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [MAG_W-1:0] clamp_magnets(input logic [MAG_W-1:0] m);
        logic [MAG_W-1:0] r;
        if (m == '0) begin
            r = 7'd1;
        end else if (m > MAG_MAX) begin
            r = MAG_MAX;
        end else begin
            r = m;
        end
        return r;
    endfunction

endpackage

@@ sv/cso_div.sv @@
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on cso_pkg for widths and the request/response structs.

module cso_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cso_pkg::div_req_t req_i,
    output cso_pkg::div_rsp_t rsp_o
);

    logic [cso_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [cso_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [cso_pkg::DIVISOR_W-1:0]  dsor_reg;
    logic [cso_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [cso_pkg::DIVISOR_W:0]    rem_sh;
    logic [cso_pkg::DIVISOR_W+1:0]  diff;
    logic                           fits;

    assign rem_sh = {rem_reg, quo_reg[cso_pkg::DIVIDEND_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsor_reg};
    assign fits   = ~diff[cso_pkg::DIVISOR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req_i.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cso_pkg::DIV_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == cso_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.start) begin
            rem_reg  <= '0;
            quo_reg  <= req_i.dividend;
            dsor_reg <= req_i.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[cso_pkg::DIVISOR_W-1:0] : rem_sh[cso_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[cso_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp_o.done     = done_reg;
    assign rsp_o.quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req_i.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && cnt_reg == '0)
        else $error("divider done with steps outstanding");

endmodule

@@ sv/cadence_speed_odometer.sv @@
`timescale 1ns / 1ps
// Cadence, road speed and odometer from millisecond pulse ticks.
// Top level; depends on cso_pkg and the shared divider cso_div.
//
// One s_ transfer is one 1 ms tick carrying pedal pulse, direction and wheel
// pulse flags. Each tick gives exactly one m_ transfer holding cadence (rpm),
// speed (0.1 km/h) and odometer (m).
// A tick runs through three back-to-back divisions on one shared 18-step
// restoring divider: crank rate, circumference per magnet, and wheel rate.
// One state (S_CALC) forms the intervals, each division hands off to the next
// on the divider's done strobe, and S_DONE loads the output register: the result
// is offered, and s_tready rises again, at that same edge. A new tick is taken
// only after the previous tick's result has been loaded into the output register.
// The result sits in an output register, so a new tick is taken while the
// previous result is still waiting; a tick whose result cannot be loaded
// because m_tready is held low waits at the end until the register frees.
// cfg_ready is always high; write only while no tick is in progress.
// A write to start_distance loads the odometer at once.
// Reset (aresetn low, synchronous) restores the configuration registers to their
// defaults and clears the millisecond clock, the pulse count, cadence, speed and the odometer.

module cadence_speed_odometer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pedal_pulse, [1] pedal_forward, [2] wheel_pulse
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [10:0] cadence_rpm, [22:11] speed_tenths, [54:23] distance_m
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DIVP = 3'd2;
    localparam logic [2:0] S_DIVC = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // configuration
    logic [9:0]                     pedal_min_reg;
    logic [9:0]                     wheel_min_reg;
    logic [15:0]                    pedal_to_reg;
    logic [15:0]                    wheel_to_reg;
    logic [cso_pkg::CIRC_W-1:0]     circ_reg;
    logic [cso_pkg::MAG_W-1:0]      pedal_mag_reg;
    logic [cso_pkg::MAG_W-1:0]      wheel_mag_reg;

    // state
    logic [2:0]                     state_reg;
    logic [31:0]                    now_reg;
    logic [31:0]                    pedal_last_reg;
    logic [31:0]                    wheel_last_reg;
    logic [cso_pkg::COUNT_W-1:0]    count_reg;
    logic [cso_pkg::RPM_W-1:0]      rpm_reg;
    logic [cso_pkg::SPEED_W-1:0]    speed_reg;
    logic [cso_pkg::DIST_W-1:0]     odometer_reg;
    logic                           m_tvalid_reg;

    // per-tick working registers
    logic                           pp_reg;
    logic                           fwd_reg;
    logic                           wp_reg;
    logic                           pacc_reg;
    logic                           pto_reg;
    logic                           wacc_reg;
    logic                           wto_reg;
    logic                           odo_step_reg;
    logic [cso_pkg::ODO_INC_W-1:0]  odo_inc_reg;
    logic [31:0]                    wi_reg;
    logic [55:0]                    m_tdata_reg;

    logic                           in_xfer;
    logic                           cfg_wr;
    logic                           out_load;
    logic [31:0]                    pi;
    logic [31:0]                    wi;
    logic                           pacc;
    logic                           wacc;
    logic [cso_pkg::MAG_W-1:0]      pm_c;
    logic [cso_pkg::MAG_W-1:0]      wm_c;
    logic [cso_pkg::MAG_W-1:0]      pm_idx;
    logic [cso_pkg::COUNT_W-1:0]    cnt_plus;
    logic [cso_pkg::COUNT_W-1:0]    cnt_limit;
    logic [24:0]                    circ_scaled;
    logic [cso_pkg::SPEED_W-1:0]    cpm;
    logic [cso_pkg::DIVIDEND_W-1:0] speed_num;
    logic [cso_pkg::DIST_W-1:0]     odo_next;
    logic [cso_pkg::RPM_W-1:0]      rpm_sat;
    logic [cso_pkg::SPEED_W-1:0]    speed_sat;

    cso_pkg::div_req_t              div_req;
    cso_pkg::div_rsp_t              div_rsp;

    cso_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (div_req),
        .rsp_o   (div_rsp)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // now_reg already holds this tick's time while in S_CALC
    assign pi   = now_reg - pedal_last_reg;
    assign wi   = now_reg - wheel_last_reg;
    assign pacc = pp_reg && (pi > {22'd0, pedal_min_reg});
    assign wacc = wp_reg && (wi > {22'd0, wheel_min_reg});

    assign pm_c      = cso_pkg::clamp_magnets(pedal_mag_reg);
    assign wm_c      = cso_pkg::clamp_magnets(wheel_mag_reg);
    assign pm_idx    = pm_c - 7'd1;
    assign cnt_plus  = count_reg + 13'd1;
    assign cnt_limit = {6'd0, wm_c} * cso_pkg::REVS_PER_STEP;

    // circumference / 10 by reciprocal
    assign circ_scaled = {13'd0, circ_reg} * {12'd0, cso_pkg::RECIP_TEN};

    // (circumference / magnets) * 36 as shift-add
    assign cpm       = div_rsp.quotient[cso_pkg::SPEED_W-1:0];
    assign speed_num = {1'b0, cpm, 5'd0} + {4'd0, cpm, 2'd0};

    assign rpm_sat   = (div_rsp.quotient[cso_pkg::DIVIDEND_W-1:cso_pkg::RPM_W] != '0)
                       ? '1 : div_rsp.quotient[cso_pkg::RPM_W-1:0];
    assign speed_sat = (div_rsp.quotient[cso_pkg::DIVIDEND_W-1:cso_pkg::SPEED_W] != '0)
                       ? '1 : div_rsp.quotient[cso_pkg::SPEED_W-1:0];

    assign odo_next  = odometer_reg
                       + (odo_step_reg ? {23'd0, odo_inc_reg} : cso_pkg::DIST_W'(0));

    always_comb begin
        div_req = '0;
        case (state_reg)
            S_CALC: begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b00, cso_pkg::PEDAL_NUM[pm_idx[5:0]]};
                div_req.divisor  = pi;
            end
            S_DIVP: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {6'd0, circ_reg};
                div_req.divisor  = {25'd0, wm_c};
            end
            S_DIVC: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = speed_num;
                div_req.divisor  = wi_reg;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pedal_min_reg  <= 10'd40;
            wheel_min_reg  <= 10'd140;
            pedal_to_reg   <= 16'd250;
            wheel_to_reg   <= 16'd1500;
            circ_reg       <= 12'd2000;
            pedal_mag_reg  <= 7'd1;
            wheel_mag_reg  <= 7'd1;
            now_reg        <= '0;
            pedal_last_reg <= '0;
            wheel_last_reg <= '0;
            count_reg      <= '0;
            rpm_reg        <= '0;
            speed_reg      <= '0;
            odometer_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            pacc_reg       <= 1'b0;
            pto_reg        <= 1'b0;
            wacc_reg       <= 1'b0;
            wto_reg        <= 1'b0;
            odo_step_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    cso_pkg::CFG_PEDAL_MIN:  pedal_min_reg <= cfg_data[9:0];
                    cso_pkg::CFG_WHEEL_MIN:  wheel_min_reg <= cfg_data[9:0];
                    cso_pkg::CFG_PEDAL_TO:   pedal_to_reg  <= cfg_data[15:0];
                    cso_pkg::CFG_WHEEL_TO:   wheel_to_reg  <= cfg_data[15:0];
                    cso_pkg::CFG_CIRC:       circ_reg      <= cfg_data[11:0];
                    cso_pkg::CFG_START_DIST: odometer_reg  <= cfg_data;
                    cso_pkg::CFG_PEDAL_MAG:  pedal_mag_reg <= cfg_data[6:0];
                    cso_pkg::CFG_WHEEL_MAG:  wheel_mag_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end

            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        now_reg   <= now_reg + 32'd1;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    pacc_reg <= pacc;
                    wacc_reg <= wacc;
                    pto_reg  <= pi > {16'd0, pedal_to_reg};
                    wto_reg  <= wi > {16'd0, wheel_to_reg};
                    odo_step_reg <= 1'b0;
                    if (pacc) begin
                        pedal_last_reg <= now_reg;
                    end
                    if (wacc) begin
                        wheel_last_reg <= now_reg;
                        if (cnt_plus >= cnt_limit) begin
                            count_reg    <= '0;
                            odo_step_reg <= 1'b1;
                        end else begin
                            count_reg <= cnt_plus;
                        end
                    end
                    state_reg <= S_DIVP;
                end
                S_DIVP: begin
                    if (div_rsp.done) begin
                        if (pacc_reg) begin
                            rpm_reg <= fwd_reg ? rpm_sat : '0;
                        end else if (pto_reg) begin
                            rpm_reg <= '0;
                        end
                        state_reg <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (div_rsp.done) begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        if (wacc_reg) begin
                            speed_reg <= speed_sat;
                        end else if (wto_reg) begin
                            speed_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        odometer_reg <= odo_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pp_reg  <= s_tdata[0];
            fwd_reg <= s_tdata[1];
            wp_reg  <= s_tdata[2];
        end
        if (state_reg == S_CALC) begin
            wi_reg      <= wi;
            odo_inc_reg <= circ_scaled[24:16];
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, odo_next, speed_reg, rpm_reg};
        end
    end

    a_accept_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == S_CALC)
        else $error("accepted tick did not start interval calculation");

    a_div_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIVP || state_reg == S_DIVC
                          || state_reg == S_DIVW))
        else $error("divider finished outside a division step");

    a_odo_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_DONE && !cfg_wr) |=> odometer_reg == $past(odometer_reg))
        else $error("odometer changed outside result load or config write");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result offered without finishing a tick");

endmodule
